// ----- src/crc32_msb_first_mixed_width_defines.svh -----
// ----------------------------------------------------------------------------
// crc32 mixed width assertion macros
// shared assertion forms for the crc32 checker
// ----------------------------------------------------------------------------
`ifndef CRC32_MSB_FIRST_MIXED_WIDTH_DEFINES_SVH
`define CRC32_MSB_FIRST_MIXED_WIDTH_DEFINES_SVH

// clocked assertion with async active-low reset as disable
`define CRC32MW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: assertion failed");

// same, with a caller supplied message
`define CRC32MW_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

`endif

// ----- src/crc32mw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32 mixed width package
// shared types, codes and the single-bit crc step
// ----------------------------------------------------------------------------
package crc32mw_pkg;

	localparam int CRC_W = 32;

	localparam logic [CRC_W-1:0] CRC_TOP_BIT   = 32'h8000_0000;
	localparam logic [CRC_W-1:0] POLY_RESET    = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] INIT_RESET    = 32'hFFFF_FFFF;

	// size codes of an input word; the unused code acts as a full word
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	typedef enum logic [0:0] {
		CFG_POLYNOMIAL    = 1'b0,
		CFG_INITIAL_VALUE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TB_LOAD,
		TB_RUN,
		TB_IDLE
	} tb_state_t;

	typedef logic [CRC_W-1:0] crc_t;

	// entry k: polynomial advanced k more shift steps
	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_tab_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tb_status_t;

	function automatic crc_t crc_step(input crc_t v, input crc_t poly);
		crc_t r;
		r = {v[CRC_W-2:0], 1'b0};
		if ((v & CRC_TOP_BIT) != '0) begin
			r = r ^ poly;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/crc32mw_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32 fold table builder
// walks the polynomial shift by shift and keeps each value in a 32-entry table
// ----------------------------------------------------------------------------
module crc32mw_table
	import crc32mw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire crc_t       poly,
	output crc_tab_t        tab,
	output tb_status_t      status
);

	tb_state_t state_q;
	tb_state_t state_next;
	logic [4:0] cnt_q;
	crc_t       walk_q;
	crc_tab_t   tab_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TB_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == TB_RUN) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_next  = state_q;
		status.busy = 1'b1;
		status.done = 1'b0;
		case (state_q)
			TB_LOAD: begin
				state_next = TB_RUN;
			end
			TB_RUN: begin
				if (cnt_q == 5'd31) begin
					state_next  = TB_IDLE;
					status.done = 1'b1;
				end
			end
			TB_IDLE: begin
				status.busy = 1'b0;
				if (start) begin
					state_next = TB_LOAD;
				end
			end
			default: begin
				state_next = TB_LOAD;
			end
		endcase
	end

	// shift line: first value pushed ends up in entry zero
	always_ff @(posedge clk) begin
		if (state_q == TB_LOAD) begin
			walk_q <= poly;
		end else if (state_q == TB_RUN) begin
			walk_q <= crc_step(walk_q, poly);
			tab_q  <= {walk_q, tab_q[CRC_W-1:1]};
		end
	end

	assign tab = tab_q;

endmodule
`default_nettype wire

// ----- src/crc32mw_fold.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32 fold network
// folds one byte, halfword or word into the crc with the step table
// ----------------------------------------------------------------------------
module crc32mw_fold
	import crc32mw_pkg::*;
(
	input  wire logic [31:0] data_word,
	input  wire logic [1:0]  size,
	input  wire logic        first,
	input  wire crc_t        crc,
	input  wire crc_t        init,
	input  wire crc_tab_t    tab,
	output crc_t             crc_next
);

	crc_t base;
	crc_t x;
	crc_t acc32;
	crc_t acc16;
	crc_t acc8;

	assign base = first ? init : crc;

	always_comb begin
		case (size)
			SIZE_BYTE: begin
				x = base ^ {data_word[7:0], 24'h0};
			end
			SIZE_HALF: begin
				x = base ^ {data_word[15:0], 16'h0};
			end
			default: begin
				x = base ^ data_word;
			end
		endcase
	end

	always_comb begin
		acc32 = '0;
		acc16 = '0;
		acc8  = '0;
		for (int j = 0; j < 32; j++) begin
			if (x[j]) begin
				acc32 = acc32 ^ tab[j];
			end
		end
		for (int j = 0; j < 16; j++) begin
			if (x[j+16]) begin
				acc16 = acc16 ^ tab[j];
			end
		end
		for (int j = 0; j < 8; j++) begin
			if (x[j+24]) begin
				acc8 = acc8 ^ tab[j];
			end
		end
	end

	always_comb begin
		case (size)
			SIZE_BYTE: begin
				crc_next = {x[23:0], 8'h0} ^ acc8;
			end
			SIZE_HALF: begin
				crc_next = {x[15:0], 16'h0} ^ acc16;
			end
			default: begin
				crc_next = acc32;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/crc32_msb_first_mixed_width.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32 msb-first mixed width
// running non-reflected crc32 over a stream of bytes, halfwords and words
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with data_word, size and first; a word
//   is taken at an edge where in_valid is high and in_stall low. first reloads
//   the initial value before the word is folded in
//   output channel: out_valid / out_stall with crc_value, the crc after each
//   word; one result word per input word, in order
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 is the polynomial, index 1 the initial value
//   a taken word passes the input register, then the result register, to the output
//   throughput: one word per clock unless a stall or a table build holds it; the
//   crc feedback is one combinational xor network over a 32-entry table for every size
//   table build: after reset and after each polynomial write the step table
//   is rebuilt (load, then run); in_stall is high and cfg_ready low meanwhile
//   reset: polynomial 0x04C11DB7, initial value and crc 0xFFFFFFFF
//   receiver stall: the result holds; one more word can sit in the input
//   register before in_stall rises
// ----------------------------------------------------------------------------
module crc32_msb_first_mixed_width
	import crc32mw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [1:0]  size,
	input  wire logic        first,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      crc_value,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire cfg_idx_t    cfg_index,
	input  wire logic [31:0] cfg_data
);

	// configuration registers
	crc_t poly_q;
	crc_t init_q;

	// input register
	logic        valid_s1;
	logic [31:0] data_s1;
	logic [1:0]  size_s1;
	logic        first_s1;

	// result register, which is also the running crc
	logic out_valid_q;
	crc_t crc_q;

	crc_tab_t   tab;
	tb_status_t tb_status;
	crc_t       crc_next;
	logic       cfg_write;
	logic       poly_write;
	logic       load_s1;
	logic       advance;

	assign cfg_ready  = !tb_status.busy;
	assign cfg_write  = cfg_valid && cfg_ready;
	assign poly_write = cfg_write && (cfg_index == CFG_POLYNOMIAL);

	// the input register moves on whenever the result slot is free or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = tb_status.busy || (valid_s1 && out_valid_q && out_stall);
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			init_q <= INIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_POLYNOMIAL:    poly_q <= cfg_data;
				CFG_INITIAL_VALUE: init_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	crc32mw_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (poly_write),
		.poly   (poly_q),
		.tab    (tab),
		.status (tb_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1  <= data_word;
			size_s1  <= size;
			first_s1 <= first;
		end
	end

	crc32mw_fold u_fold (
		.data_word (data_s1),
		.size      (size_s1),
		.first     (first_s1),
		.crc       (crc_q),
		.init      (init_q),
		.tab       (tab),
		.crc_next  (crc_next)
	);

	// crc only moves when its result is taken or the slot is empty,
	// so a stalled result never changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= INIT_RESET;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			crc_q       <= crc_next;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

endmodule
`default_nettype wire

// ----- src/crc32mw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "crc32_msb_first_mixed_width_defines.svh"
// ----------------------------------------------------------------------------
// crc32 mixed width checker
// port-level checks on the crc block, bound to the top level
// ----------------------------------------------------------------------------
module crc32mw_checker
	import crc32mw_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] crc_value,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire cfg_idx_t    cfg_index
);

	logic out_held;
	logic poly_wr;
	logic building;
	logic idle_now;
	logic idle_in;

	assign out_held = out_valid && out_stall;
	assign poly_wr  = cfg_valid && cfg_ready && (cfg_index == CFG_POLYNOMIAL);
	assign building = !cfg_ready;
	assign idle_now = cfg_ready && !out_valid;
	assign idle_in  = !in_valid && cfg_ready;

	// a stalled result stays put
	`CRC32MW_ASSERT(a_out_hold, clk, arst_n, out_held |=> out_valid && $stable(crc_value))

	// a polynomial write starts a table rebuild
	`CRC32MW_ASSERT(a_poly_rebuild, clk, arst_n, poly_wr |=> building && in_stall)

	// no word is taken while the table is being rebuilt
	`CRC32MW_ASSERT_MSG(a_build_blocks, clk, arst_n, building |-> in_stall, "input open in build")

	// an idle pipe with a free output never refuses a word
	`CRC32MW_ASSERT(a_no_false_stall, clk, arst_n, idle_now && $past(idle_in) |-> !in_stall)

endmodule

bind crc32_msb_first_mixed_width crc32mw_checker u_crc32mw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.crc_value (crc_value),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);
`default_nettype wire
